// File: design/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion macros for the record ring queue RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assertion that is switched off while reset is held.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assertion that is checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: design/vrrq_pkg.sv
// ============================================================================
// Record ring queue package
// Constants, codes and control/status structs shared by the queue modules.
// ============================================================================
package vrrq_pkg;

    // Ring storage geometry.
    localparam int BUFFER_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int PTR_W        = ADDR_W + 1;
    localparam int MIN_RING     = 8;
    localparam int HEADER_BYTES = 4;
    localparam int MAX_RECORD   = 63;

    // Field widths.
    localparam int CMD_W      = 3;
    localparam int LEN_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_HDR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BYTE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORD   = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic do_exec;
        logic addr_stream;
        logic byte_emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic exec_streams;
        logic last_byte;
    } stat_t;

endpackage

// File: design/variable_record_ring_queue_top.sv
// ============================================================================
// Variable-length record ring queue
// Byte ring holding length-prefixed records with push, pop, peek and delete.
// ============================================================================
// Items are handled one at a time. A push header, push byte, delete, clear or
// unknown command is accepted in S_IDLE and executed in S_EXEC, which loads its
// single result. A pop or peek that succeeds also loads its result in S_EXEC,
// then sends every payload byte through the registered read port of the ring
// memory: the byte is addressed in S_RDREQ and returned and loaded in S_RDOUT.
// Output stalls hold the controller in S_EXEC or S_RDOUT. The configuration port
// is always ready; writing buffer_bytes clears the queue. The ring memory needs
// no clearing pass after reset.
module variable_record_ring_queue_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input items.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [vrrq_pkg::S_DATA_W-1:0]      s_tdata,   // length, in_byte, reader_capacity
    input  logic [vrrq_pkg::CMD_W-1:0]         s_tuser,   // command
    // Result items.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vrrq_pkg::M_DATA_W-1:0]      m_tdata,   // status, record_length,
                                                          // out_byte, record_count
    output logic                               m_tuser,   // byte_valid
    output logic                               m_tlast,
    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vrrq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vrrq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    vrrq_pkg::cmd_t  ctrl_cmd;
    vrrq_pkg::stat_t dp_stat;

    assign cfg_ready = 1'b1;

    vrrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_stat  (dp_stat),
        .ctrl_cmd (ctrl_cmd)
    );

    vrrq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl_cmd  (ctrl_cmd),
        .dp_stat   (dp_stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: design/vrrq_ram.sv
// ============================================================================
// Generic RAM
// Single write port, single read port, registered read data.
// ============================================================================
module vrrq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/vrrq_ctrl.sv
// ============================================================================
// Record ring queue controller
// Sequences item acceptance, execution and payload byte streaming.
// ============================================================================
`include "assert_macros.svh"

module vrrq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  vrrq_pkg::stat_t dp_stat,
    output vrrq_pkg::cmd_t  ctrl_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_RDREQ = 2'd2;
    localparam logic [1:0] S_RDOUT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and datapath commands.
    always_comb begin
        state_next           = state_reg;
        ctrl_cmd             = '0;
        s_tready             = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl_cmd.take_item = 1'b1;
                    state_next         = S_EXEC;
                end
            end
            S_EXEC: begin
                if (dp_stat.out_free) begin
                    ctrl_cmd.do_exec = 1'b1;
                    state_next       = dp_stat.exec_streams ? S_RDREQ : S_IDLE;
                end
            end
            S_RDREQ: begin
                ctrl_cmd.addr_stream = 1'b1;
                state_next           = S_RDOUT;
            end
            S_RDOUT: begin
                ctrl_cmd.addr_stream = 1'b1;
                if (dp_stat.out_free) begin
                    ctrl_cmd.byte_emit = 1'b1;
                    state_next         = dp_stat.last_byte ? S_IDLE : S_RDREQ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // At most one item action is issued in any cycle.
    `ASSERT_ALWAYS(a_single_action, aclk,
        $onehot0({ctrl_cmd.take_item, ctrl_cmd.do_exec, ctrl_cmd.byte_emit}),
        "controller issued more than one item action")

endmodule

// File: design/vrrq_datapath.sv
// ============================================================================
// Record ring queue datapath
// Pointers, counters, ring memory, configuration and the output register.
// ============================================================================
`include "assert_macros.svh"

module vrrq_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  vrrq_pkg::cmd_t                      ctrl_cmd,
    output vrrq_pkg::stat_t                     dp_stat,
    input  logic [vrrq_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic [vrrq_pkg::CMD_W-1:0]          s_tuser,
    input  logic                                cfg_wr,
    input  logic [vrrq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vrrq_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [vrrq_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    localparam int PW = vrrq_pkg::PTR_W;
    localparam int AW = vrrq_pkg::ADDR_W;
    localparam int LW = vrrq_pkg::LEN_W;
    localparam int CW = vrrq_pkg::COUNT_W;
    localparam int BW = vrrq_pkg::BYTE_W;
    localparam int SW = vrrq_pkg::STATUS_W;

    // Latched input item.
    logic [vrrq_pkg::CMD_W-1:0] cmd_reg;
    logic [LW-1:0]              len_reg;
    logic [BW-1:0]              byte_reg;
    logic [LW-1:0]              cap_reg;

    // Queue state and configuration.
    logic [PW-1:0] head_reg,  head_next;
    logic [PW-1:0] tail_reg,  tail_next;
    logic [PW-1:0] lend_reg,  lend_next;
    logic [PW-1:0] wp_reg,    wp_next;
    logic [LW-1:0] btp_reg,   btp_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] size_reg,  size_next;
    logic [LW-1:0] maxrec_reg, maxrec_next;

    // Payload streaming.
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] remain_reg, remain_next;
    logic [LW-1:0] rlen_reg,   rlen_next;

    // Output register.
    logic          m_valid_reg, m_valid_next;
    logic [SW-1:0] o_status_reg, o_status_next;
    logic [LW-1:0] o_len_reg,    o_len_next;
    logic [BW-1:0] o_byte_reg,   o_byte_next;
    logic          o_bv_reg,     o_bv_next;
    logic          o_last_reg,   o_last_next;
    logic [CW-1:0] o_count_reg,  o_count_next;

    // Ring memory port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [BW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [BW-1:0] ram_rdata;

    // Helper values for execution.
    logic [LW-1:0] hd_len;
    logic          empty;
    logic          is_read;
    logic          pop_big;
    logic [PW-1:0] delta;
    logic [PW-1:0] end_v;
    logic [PW-1:0] next_head;
    logic [PW-1:0] cfg_size;
    logic          out_free;

    // Execution result fields.
    logic [SW-1:0] res_status;
    logic [LW-1:0] res_len;
    logic          res_last;

    vrrq_ram #(
        .WIDTH (BW),
        .DEPTH (vrrq_pkg::BUFFER_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The head length byte is read while idle; payload bytes while streaming.
    assign ram_raddr = ctrl_cmd.addr_stream ? rd_ptr_reg : head_reg[AW-1:0];

    assign hd_len    = ram_rdata[LW-1:0];
    assign empty     = (head_reg == tail_reg);
    assign is_read   = (cmd_reg == vrrq_pkg::CMD_POP) || (cmd_reg == vrrq_pkg::CMD_PEEK);
    assign pop_big   = (cmd_reg == vrrq_pkg::CMD_POP) && (hd_len > cap_reg);
    assign delta     = PW'(len_reg) + PW'(vrrq_pkg::HEADER_BYTES);
    assign end_v     = tail_reg + delta;
    assign next_head = head_reg + PW'(vrrq_pkg::HEADER_BYTES) + PW'(hd_len);
    assign out_free  = !m_valid_reg || m_tready;

    // Ring size from a configuration write, saturated to the usable range.
    always_comb begin
        cfg_size = PW'(cfg_data);
        if (cfg_data > vrrq_pkg::CFG_DATA_W'(vrrq_pkg::BUFFER_DEPTH)) begin
            cfg_size = PW'(vrrq_pkg::BUFFER_DEPTH);
        end else if (cfg_data < vrrq_pkg::CFG_DATA_W'(vrrq_pkg::MIN_RING)) begin
            cfg_size = PW'(vrrq_pkg::MIN_RING);
        end
    end

    // Status toward the controller.
    assign dp_stat.out_free     = out_free;
    assign dp_stat.exec_streams = is_read && !empty && !pop_big && (hd_len != '0);
    assign dp_stat.last_byte    = (remain_reg == LW'(1));

    // Command execution, byte streaming and configuration writes.
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        lend_next     = lend_reg;
        wp_next       = wp_reg;
        btp_next      = btp_reg;
        count_next    = count_reg;
        size_next     = size_reg;
        maxrec_next   = maxrec_reg;
        rd_ptr_next   = rd_ptr_reg;
        remain_next   = remain_reg;
        rlen_next     = rlen_reg;
        ram_we        = 1'b0;
        ram_waddr     = wp_reg[AW-1:0];
        ram_wdata     = byte_reg;
        res_status    = vrrq_pkg::ST_OK;
        res_len       = '0;
        res_last      = 1'b1;
        if (ctrl_cmd.do_exec) begin
            case (cmd_reg)
                vrrq_pkg::CMD_PUSH_BYTE: begin
                    if (btp_reg == '0) begin
                        res_status = vrrq_pkg::ST_OVERFLOW;
                    end else begin
                        ram_we   = 1'b1;
                        wp_next  = wp_reg + PW'(1);
                        btp_next = btp_reg - LW'(1);
                        if (btp_reg == LW'(1)) begin
                            tail_next  = wp_reg + PW'(1);
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                vrrq_pkg::CMD_PUSH_HDR: begin
                    btp_next = '0;
                    if (len_reg > maxrec_reg) begin
                        res_status = vrrq_pkg::ST_TOO_BIG;
                    end else if (end_v >= size_reg) begin
                        // Record does not fit before the end: wrap to zero.
                        if ((tail_reg < head_reg) || (delta >= head_reg)) begin
                            res_status = vrrq_pkg::ST_OVERFLOW;
                        end else begin
                            lend_next = tail_reg;
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = BW'(len_reg);
                            wp_next   = PW'(vrrq_pkg::HEADER_BYTES);
                            btp_next  = len_reg;
                            tail_next = (len_reg == '0) ? PW'(vrrq_pkg::HEADER_BYTES) : '0;
                            if (len_reg == '0) begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                    end else if ((tail_reg < head_reg) && (end_v >= head_reg)) begin
                        res_status = vrrq_pkg::ST_OVERFLOW;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = tail_reg[AW-1:0];
                        ram_wdata = BW'(len_reg);
                        wp_next   = tail_reg + PW'(vrrq_pkg::HEADER_BYTES);
                        btp_next  = len_reg;
                        if (len_reg == '0) begin
                            tail_next  = tail_reg + PW'(vrrq_pkg::HEADER_BYTES);
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                vrrq_pkg::CMD_POP, vrrq_pkg::CMD_PEEK, vrrq_pkg::CMD_DELETE: begin
                    btp_next = '0;
                    if (empty) begin
                        res_status = vrrq_pkg::ST_EMPTY;
                    end else if (pop_big) begin
                        res_status = vrrq_pkg::ST_TOO_BIG;
                        res_len    = hd_len;
                    end else begin
                        if (is_read) begin
                            res_len     = hd_len;
                            res_last    = (hd_len == '0);
                            rd_ptr_next = head_reg[AW-1:0] + AW'(vrrq_pkg::HEADER_BYTES);
                            remain_next = hd_len;
                            rlen_next   = hd_len;
                        end
                        // Pop and delete remove the head record.
                        if (cmd_reg != vrrq_pkg::CMD_PEEK) begin
                            if (next_head == tail_reg) begin
                                head_next = '0;
                                tail_next = '0;
                            end else if (next_head == lend_reg) begin
                                head_next = '0;
                                lend_next = size_reg;
                            end else begin
                                head_next = next_head;
                            end
                            if (count_reg != '0) begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                    end
                end
                vrrq_pkg::CMD_CLEAR: begin
                    head_next  = '0;
                    tail_next  = '0;
                    wp_next    = '0;
                    lend_next  = size_reg;
                    btp_next   = '0;
                    count_next = '0;
                end
                default: begin
                    res_status = vrrq_pkg::ST_OK;
                end
            endcase
        end else if (ctrl_cmd.byte_emit) begin
            rd_ptr_next = rd_ptr_reg + AW'(1);
            remain_next = remain_reg - LW'(1);
        end
        // The user must send configuration writes only while the queue is idle; the block does not enforce it.
        if (cfg_wr) begin
            if (cfg_index == vrrq_pkg::CFG_BUFFER_BYTES) begin
                size_next  = cfg_size;
                head_next  = '0;
                tail_next  = '0;
                wp_next    = '0;
                lend_next  = cfg_size;
                btp_next   = '0;
                count_next = '0;
            end else begin
                maxrec_next = cfg_data[LW-1:0];
            end
        end
    end

    // Output register loading.
    always_comb begin
        m_valid_next  = m_valid_reg;
        o_status_next = o_status_reg;
        o_len_next    = o_len_reg;
        o_byte_next   = o_byte_reg;
        o_bv_next     = o_bv_reg;
        o_last_next   = o_last_reg;
        o_count_next  = o_count_reg;
        if (ctrl_cmd.do_exec) begin
            m_valid_next  = 1'b1;
            o_status_next = res_status;
            o_len_next    = res_len;
            o_byte_next   = '0;
            o_bv_next     = 1'b0;
            o_last_next   = res_last;
            o_count_next  = count_next;
        end else if (ctrl_cmd.byte_emit) begin
            m_valid_next  = 1'b1;
            o_status_next = vrrq_pkg::ST_OK;
            o_len_next    = rlen_reg;
            o_byte_next   = ram_rdata;
            o_bv_next     = 1'b1;
            o_last_next   = (remain_reg == LW'(1));
            o_count_next  = count_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            lend_reg    <= PW'(vrrq_pkg::BUFFER_DEPTH);
            wp_reg      <= '0;
            btp_reg     <= '0;
            count_reg   <= '0;
            size_reg    <= PW'(vrrq_pkg::BUFFER_DEPTH);
            maxrec_reg  <= LW'(vrrq_pkg::MAX_RECORD);
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            lend_reg    <= lend_next;
            wp_reg      <= wp_next;
            btp_reg     <= btp_next;
            count_reg   <= count_next;
            size_reg    <= size_next;
            maxrec_reg  <= maxrec_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (ctrl_cmd.take_item) begin
            cmd_reg  <= s_tuser;
            len_reg  <= s_tdata[LW-1:0];
            byte_reg <= s_tdata[LW+BW-1:LW];
            cap_reg  <= s_tdata[2*LW+BW-1:LW+BW];
        end
        rd_ptr_reg   <= rd_ptr_next;
        rlen_reg     <= rlen_next;
        o_status_reg <= o_status_next;
        o_len_reg    <= o_len_next;
        o_byte_reg   <= o_byte_next;
        o_bv_reg     <= o_bv_next;
        o_last_reg   <= o_last_next;
        o_count_reg  <= o_count_next;
    end

    // Result fields, lowest bit first: status, record_length, out_byte, record_count.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, o_count_reg, o_byte_reg, o_len_reg, o_status_reg};
    assign m_tuser  = o_bv_reg;
    assign m_tlast  = o_last_reg;

    // Pointers never leave the ring in use.
    `ASSERT_RST(a_tail_in_ring, aclk, aresetn, tail_reg < size_reg,
        "tail pointer outside the ring")
    `ASSERT_RST(a_head_in_ring, aclk, aresetn, head_reg < size_reg,
        "head pointer outside the ring")
    `ASSERT_RST(a_pending_in_ring, aclk, aresetn, (btp_reg != '0) |-> (wp_reg < size_reg),
        "pending record write pointer outside the ring")

endmodule
